FILE: hdl/vsm_pkg.sv
// shared types and constants for the sparse matrix-vector block
`timescale 1ns / 1ps

package vsm_pkg;

  // fixed field widths
  localparam int unsigned ROW_W  = 20;
  localparam int unsigned COL_W  = 13;
  localparam int unsigned IDX_W  = 12;
  localparam int unsigned SIZE_W = 8;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned ACC_W  = 64;
  localparam int unsigned ADDR_W = 3;

  // action codes
  localparam logic [1:0] ACT_LOAD  = 2'd0;
  localparam logic [1:0] ACT_MAT   = 2'd1;
  localparam logic [1:0] ACT_CLOSE = 2'd2;
  localparam logic [1:0] ACT_NOP   = 2'd3;

  // register indexes, taken from paddr bit 2
  localparam logic REG_FIRST_ROW = 1'b0;
  localparam logic REG_FINAL_ROW = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_ACC,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic [ROW_W-1:0] first_row;
    logic [ROW_W-1:0] final_row;
    logic             first_row_wr;
  } cfg_t;

  typedef struct packed {
    logic mul_en;
    logic acc_en;
    logic term_ok;
    logic clear;
  } mac_ctrl_t;

  typedef struct packed {
    logic [DATA_W-1:0] y_value;
    logic              saturated;
    logic              col_error;
  } row_res_t;

endpackage

FILE: hdl/vsm_ram.sv
// generic single-write, single-read RAM with registered read data
`timescale 1ns / 1ps

module vsm_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hdl/vsm_regs.sv
// configuration registers behind the apb-style port
`timescale 1ns / 1ps

module vsm_regs (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [vsm_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready,
  output vsm_pkg::cfg_t             cfg_o
);

  logic [vsm_pkg::ROW_W-1:0] first_row_q;
  logic [vsm_pkg::ROW_W-1:0] final_row_q;
  logic                      wr_fire;
  logic                      sel;

  assign pready  = 1'b1;
  assign wr_fire = psel && penable && pwrite;
  assign sel     = paddr[2];

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_row_q <= '0;
      final_row_q <= '0;
    end else if (wr_fire) begin
      case (sel)
        vsm_pkg::REG_FIRST_ROW: first_row_q <= pwdata[vsm_pkg::ROW_W-1:0];
        vsm_pkg::REG_FINAL_ROW: final_row_q <= pwdata[vsm_pkg::ROW_W-1:0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    case (sel)
      vsm_pkg::REG_FIRST_ROW: prdata = {12'd0, first_row_q};
      vsm_pkg::REG_FINAL_ROW: prdata = {12'd0, final_row_q};
      default:                prdata = '0;
    endcase
  end

  assign cfg_o.first_row    = pwdata[vsm_pkg::ROW_W-1:0];
  assign cfg_o.final_row    = final_row_q;
  assign cfg_o.first_row_wr = wr_fire && (sel == vsm_pkg::REG_FIRST_ROW);

endmodule

FILE: hdl/vsm_mac.sv
// multiplier, saturating row accumulator and result formatting
`timescale 1ns / 1ps

module vsm_mac (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  vsm_pkg::mac_ctrl_t               ctrl_i,
  input  logic signed [vsm_pkg::DATA_W-1:0] mat_value_i,
  input  logic signed [vsm_pkg::DATA_W-1:0] vec_value_i,
  output vsm_pkg::row_res_t                res_o
);

  logic signed [vsm_pkg::ACC_W-1:0] prod_q;
  logic signed [vsm_pkg::ACC_W-1:0] row_sum_q;
  logic signed [vsm_pkg::ACC_W-1:0] row_sum_d;
  logic [1:0]                       clip_q;
  logic [1:0]                       clip_d;
  logic [vsm_pkg::ACC_W-1:0]        sum;
  logic                             ovf_pos;
  logic                             ovf_neg;
  logic                             out_fits;

  // product register
  always_ff @(posedge clk_i) begin
    if (ctrl_i.mul_en) begin
      prod_q <= mat_value_i * vec_value_i;
    end
  end

  // saturating add
  assign sum     = row_sum_q + prod_q;
  assign ovf_pos = !row_sum_q[63] && !prod_q[63] && sum[63];
  assign ovf_neg = row_sum_q[63] && prod_q[63] && !sum[63];

  always_comb begin
    row_sum_d = row_sum_q;
    clip_d    = clip_q;
    if (ctrl_i.clear) begin
      row_sum_d = '0;
      clip_d    = '0;
    end else if (ctrl_i.acc_en) begin
      if (ctrl_i.term_ok) begin
        if (ovf_pos) begin
          row_sum_d = {1'b0, {(vsm_pkg::ACC_W-1){1'b1}}};
          clip_d[0] = 1'b1;
        end else if (ovf_neg) begin
          row_sum_d = {1'b1, {(vsm_pkg::ACC_W-1){1'b0}}};
          clip_d[0] = 1'b1;
        end else begin
          row_sum_d = sum;
        end
      end else begin
        clip_d[1] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_sum_q <= '0;
      clip_q    <= '0;
    end else begin
      row_sum_q <= row_sum_d;
      clip_q    <= clip_d;
    end
  end

  // drop 16 fraction bits, clip to q16.16
  assign out_fits = (row_sum_q[63:47] == {17{1'b0}}) || (row_sum_q[63:47] == {17{1'b1}});

  always_comb begin
    if (out_fits) begin
      res_o.y_value = row_sum_q[47:16];
    end else if (row_sum_q[63]) begin
      res_o.y_value = {1'b1, {(vsm_pkg::DATA_W-1){1'b0}}};
    end else begin
      res_o.y_value = {1'b0, {(vsm_pkg::DATA_W-1){1'b1}}};
    end
    res_o.saturated = clip_q[0] || !out_fits;
    res_o.col_error = clip_q[1];
  end

endmodule

FILE: hdl/vbl_sparse_matvec_top.sv
// top level of the variable-block-length sparse matrix-vector block
// one item at a time: a vector load is written as it is accepted; a matrix value
// is read from the store on acceptance, then multiplied, then accumulated
// the output step registers the result of a row-ending value or a row close
// and stalls while an unaccepted result waits in the output register
// reset is asynchronous, active low; the vector store is not cleared
`timescale 1ns / 1ps

module vbl_sparse_matvec_top #(
  parameter int unsigned VEC_LEN   = 4096,
  parameter int unsigned MAX_BLOCK = 255
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // input channel
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [1:0]                         action_i,
  input  logic [vsm_pkg::IDX_W-1:0]          vec_index_i,
  input  logic signed [vsm_pkg::DATA_W-1:0]  vec_value_i,
  input  logic [vsm_pkg::IDX_W-1:0]          block_start_col_i,
  input  logic [vsm_pkg::SIZE_W-1:0]         block_size_i,
  input  logic signed [vsm_pkg::DATA_W-1:0]  mat_value_i,
  input  logic                               row_last_i,
  // output channel
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [vsm_pkg::ROW_W-1:0]          row_index_o,
  output logic signed [vsm_pkg::DATA_W-1:0]  y_value_o,
  output logic                               saturated_o,
  output logic                               col_error_o,
  output logic                               slice_done_o,
  // configuration port
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [vsm_pkg::ADDR_W-1:0]         paddr,
  input  logic [31:0]                        pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready
);

  localparam int unsigned AW = $clog2(VEC_LEN);
  localparam logic [vsm_pkg::SIZE_W-1:0] MAX_BLK = vsm_pkg::SIZE_W'(MAX_BLOCK);

  vsm_pkg::cfg_t      cfg;
  vsm_pkg::mac_ctrl_t mac_ctrl;
  vsm_pkg::row_res_t  row_res;
  vsm_pkg::state_e    state_q, state_d;

  logic                             accept;
  logic                             emit_fire;
  logic [vsm_pkg::SIZE_W-1:0]       block_left_q, block_left_d;
  logic [vsm_pkg::COL_W-1:0]        next_column_q, next_column_d;
  logic [vsm_pkg::ROW_W-1:0]        row_counter_q;
  logic [vsm_pkg::COL_W-1:0]        col;
  logic [vsm_pkg::SIZE_W-1:0]       size_eff;
  logic [vsm_pkg::SIZE_W-1:0]       left_base;
  logic [31:0]                      col_ext;
  logic [31:0]                      idx_ext;
  logic                             col_ok;
  logic                             load_ok;
  logic                             ram_we;
  logic                             ram_re;
  logic [vsm_pkg::DATA_W-1:0]       ram_rdata;
  logic signed [vsm_pkg::DATA_W-1:0] mat_q;
  logic                             row_last_q;
  logic                             term_ok_q;
  logic                             out_valid_q;
  logic [vsm_pkg::ROW_W-1:0]        row_index_q;
  logic [vsm_pkg::DATA_W-1:0]       y_value_q;
  logic                             saturated_q;
  logic                             col_error_q;
  logic                             slice_done_q;

  vsm_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  assign in_ready_o = (state_q == vsm_pkg::ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  // column and block length for a matrix value
  always_comb begin
    if (block_size_i == '0) begin
      size_eff = vsm_pkg::SIZE_W'(1);
    end else if (block_size_i > MAX_BLK) begin
      size_eff = MAX_BLK;
    end else begin
      size_eff = block_size_i;
    end
    if (block_left_q == '0) begin
      col       = {1'b0, block_start_col_i};
      left_base = size_eff;
    end else begin
      col       = next_column_q;
      left_base = block_left_q;
    end
  end

  assign col_ext = 32'(col);
  assign idx_ext = 32'(vec_index_i);
  assign col_ok  = col_ext < 32'(VEC_LEN);
  assign load_ok = idx_ext < 32'(VEC_LEN);
  assign ram_we  = accept && (action_i == vsm_pkg::ACT_LOAD) && load_ok;
  assign ram_re  = accept && (action_i == vsm_pkg::ACT_MAT);

  // vector store
  vsm_ram #(
    .WIDTH (vsm_pkg::DATA_W),
    .DEPTH (VEC_LEN)
  ) u_vec_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (idx_ext[AW-1:0]),
    .wdata_i (vec_value_i),
    .re_i    (ram_re),
    .raddr_i (col_ext[AW-1:0]),
    .rdata_o (ram_rdata)
  );

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= vsm_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d          = state_q;
    mac_ctrl.mul_en  = 1'b0;
    mac_ctrl.acc_en  = 1'b0;
    mac_ctrl.term_ok = term_ok_q;
    mac_ctrl.clear   = 1'b0;
    emit_fire        = 1'b0;
    case (state_q)
      vsm_pkg::ST_IDLE: begin
        if (accept) begin
          case (action_i)
            vsm_pkg::ACT_MAT:   state_d = vsm_pkg::ST_MUL;
            vsm_pkg::ACT_CLOSE: state_d = vsm_pkg::ST_EMIT;
            default:            state_d = vsm_pkg::ST_IDLE;
          endcase
        end
      end
      vsm_pkg::ST_MUL: begin
        mac_ctrl.mul_en = 1'b1;
        state_d         = vsm_pkg::ST_ACC;
      end
      vsm_pkg::ST_ACC: begin
        mac_ctrl.acc_en = 1'b1;
        state_d         = row_last_q ? vsm_pkg::ST_EMIT : vsm_pkg::ST_IDLE;
      end
      vsm_pkg::ST_EMIT: begin
        if (!out_valid_q || out_ready_i) begin
          emit_fire      = 1'b1;
          mac_ctrl.clear = 1'b1;
          state_d        = vsm_pkg::ST_IDLE;
        end
      end
      default: state_d = vsm_pkg::ST_IDLE;
    endcase
  end

  // block tracking and row counter
  always_comb begin
    block_left_d  = block_left_q;
    next_column_d = next_column_q;
    if (emit_fire) begin
      block_left_d = '0;
    end else if (ram_re) begin
      block_left_d  = left_base - vsm_pkg::SIZE_W'(1);
      next_column_d = col + vsm_pkg::COL_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      block_left_q  <= '0;
      next_column_q <= '0;
      row_counter_q <= '0;
    end else begin
      block_left_q  <= block_left_d;
      next_column_q <= next_column_d;
      if (cfg.first_row_wr) begin
        row_counter_q <= cfg.first_row;
      end else if (emit_fire) begin
        row_counter_q <= row_counter_q + vsm_pkg::ROW_W'(1);
      end
    end
  end

  // operands held for the multiply and accumulate steps
  always_ff @(posedge clk_i) begin
    if (ram_re) begin
      mat_q      <= mat_value_i;
      row_last_q <= row_last_i;
      term_ok_q  <= col_ok;
    end
  end

  vsm_mac u_mac (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (mac_ctrl),
    .mat_value_i (mat_q),
    .vec_value_i (ram_rdata),
    .res_o       (row_res)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_fire) begin
      row_index_q  <= row_counter_q;
      y_value_q    <= row_res.y_value;
      saturated_q  <= row_res.saturated;
      col_error_q  <= row_res.col_error;
      slice_done_q <= (row_counter_q == cfg.final_row);
    end
  end

  assign out_valid_o  = out_valid_q;
  assign row_index_o  = row_index_q;
  assign y_value_o    = y_value_q;
  assign saturated_o  = saturated_q;
  assign col_error_o  = col_error_q;
  assign slice_done_o = slice_done_q;

endmodule

FILE: hdl/vsm_checker.sv
// port-level checks for the sparse matrix-vector block and their bind
`timescale 1ns / 1ps

module vsm_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_valid_i,
  input logic                      in_ready_o,
  input logic [1:0]                action_i,
  input logic                      out_valid_o,
  input logic                      out_ready_i,
  input logic [vsm_pkg::ROW_W-1:0] row_index_o
);

  logic in_fire;
  assign in_fire = in_valid_i && in_ready_o;

  // a vector load finishes in its own cycle
  a_load_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && (action_i == vsm_pkg::ACT_LOAD) |=> in_ready_o)
    else $error("input not ready after a vector load");

  // a matrix value keeps the block busy through multiply and accumulate
  a_mat_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && (action_i == vsm_pkg::ACT_MAT) |=> !in_ready_o ##1 !in_ready_o)
    else $error("input ready during a multiply-accumulate");

  // a row close takes the input out of ready right after its acceptance
  a_close_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && (action_i == vsm_pkg::ACT_CLOSE) |=> !in_ready_o)
    else $error("input ready right after a row close");

  // a stalled result keeps its row index
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(row_index_o))
    else $error("result dropped or changed while stalled");

endmodule

bind vbl_sparse_matvec_top vsm_checker u_vsm_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .action_i    (action_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .row_index_o (row_index_o)
);
